/* rtl/core/tcp_udp_port_match_filter_assert.svh */
// Assertion macros shared by the checker of the port-match filter.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef TCP_UDP_PORT_MATCH_FILTER_ASSERT_SVH
`define TCP_UDP_PORT_MATCH_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TUF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TUF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tuf_pkg.sv */
// Shared types and constants of the TCP/UDP port-match filter.
// Used by every module of the block; depends on nothing.
package tuf_pkg;

  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned OutCntW       = 32;
  localparam int unsigned PosW          = 7;
  localparam int unsigned LenW          = 8;

  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [7:0]  ProtoUdp    = 8'd17;

  localparam logic [LenW-1:0] EthHdrBytes = 8'd14;
  localparam logic [LenW-1:0] IpMinBytes  = 8'd20;
  localparam logic [LenW-1:0] TcpHdrBytes = 8'd20;
  localparam logic [LenW-1:0] UdpHdrBytes = 8'd8;
  localparam logic [3:0]      IhlMin      = 4'd5;

  // Byte offsets inside the frame.
  localparam logic [PosW-1:0] PosMax      = 7'd127;
  localparam logic [PosW-1:0] PosEthType  = 7'd12;
  localparam logic [PosW-1:0] PosIhl      = 7'd14;
  localparam logic [PosW-1:0] PosTotLen   = 7'd16;
  localparam logic [PosW-1:0] PosProto    = 7'd23;
  localparam logic [PosW-1:0] PosSrcAddr  = 7'd26;
  localparam logic [PosW-1:0] PosDstAddr  = 7'd30;

  localparam logic VerdictDrop = 1'b1;
  localparam logic VerdictPass = 1'b0;

  typedef enum logic {
    CfgWatchedPort = 1'b0,
    CfgDropEnable  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]     watched_port;
    logic            drop_enable;
  } cfg_t;

  // Header fields as they stand after the current byte, plus frame length.
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [15:0]     eth_type;
    logic [3:0]      ihl;
    logic [7:0]      proto;
    logic [15:0]     tot_len;
    logic [31:0]     src_addr;
    logic [31:0]     dst_addr;
    logic [15:0]     src_port;
    logic [15:0]     dst_port;
  } hdr_t;

endpackage

/* rtl/core/tuf_cfg_regs.sv */
// APB-style register file of the port-match filter: watched port and drop enable.
// Depends on tuf_pkg for the register indexes and the config struct.
module tuf_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output tuf_pkg::cfg_t cfg_o
);
  import tuf_pkg::*;

  logic [15:0] port_q, port_d;
  logic        drop_q, drop_d;
  logic        wr_en;
  cfg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = cfg_idx_e'(paddr[2]);

  always_comb begin
    port_d = port_q;
    drop_d = drop_q;
    if (wr_en) begin
      case (idx)
        CfgWatchedPort: port_d = pwdata[15:0];
        CfgDropEnable:  drop_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CfgWatchedPort: prdata = {16'd0, port_q};
      CfgDropEnable:  prdata = {31'd0, drop_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= '0;
      drop_q <= 1'b0;
    end else begin
      port_q <= port_d;
      drop_q <= drop_d;
    end
  end

  assign cfg_o.watched_port = port_q;
  assign cfg_o.drop_enable  = drop_q;

endmodule

/* rtl/core/tuf_hdr_parse.sv */
// Per-frame header capture: byte position and the Ethernet, IPv4 and L4 fields.
// Depends on tuf_pkg; hands the fields after the current byte to the verdict stage.
module tuf_hdr_parse (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output tuf_pkg::hdr_t hdr_o
);
  import tuf_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] l4_pos;
  hdr_t            cur_q;
  hdr_t            cap;
  logic            in_l4;

  // The L4 header starts right after the IP header; its length is fixed from
  // byte 14 on, so port capture is only allowed past that byte.
  assign l4_pos = EthHdrBytes[PosW-1:0] + {1'b0, cur_q.ihl, 2'b00};
  assign in_l4  = pos_q > PosIhl;

  always_comb begin
    cap     = cur_q;
    cap.len = {1'b0, pos_q} + LenW'(1);
    if (pos_q != PosMax) begin
      if (pos_q == PosEthType || pos_q == PosEthType + 7'd1) begin
        cap.eth_type = {cur_q.eth_type[7:0], byte_i};
      end
      if (pos_q == PosIhl) begin
        cap.ihl = byte_i[3:0];
      end
      if (pos_q == PosTotLen || pos_q == PosTotLen + 7'd1) begin
        cap.tot_len = {cur_q.tot_len[7:0], byte_i};
      end
      if (pos_q == PosProto) begin
        cap.proto = byte_i;
      end
      if (pos_q inside {[PosSrcAddr:PosSrcAddr + 7'd3]}) begin
        cap.src_addr = {cur_q.src_addr[23:0], byte_i};
      end
      if (pos_q inside {[PosDstAddr:PosDstAddr + 7'd3]}) begin
        cap.dst_addr = {cur_q.dst_addr[23:0], byte_i};
      end
      if (in_l4 && (pos_q == l4_pos || pos_q == l4_pos + 7'd1)) begin
        cap.src_port = {cur_q.src_port[7:0], byte_i};
      end
      if (in_l4 && (pos_q == l4_pos + 7'd2 || pos_q == l4_pos + 7'd3)) begin
        cap.dst_port = {cur_q.dst_port[7:0], byte_i};
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      if (last_i) begin
        pos_d = '0;
      end else if (pos_q != PosMax) begin
        pos_d = pos_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cur_q <= '0;
    end else begin
      pos_q <= pos_d;
      if (step_i) begin
        cur_q <= last_i ? '0 : cap;
      end
    end
  end

  assign hdr_o = cap;

endmodule

/* rtl/core/tuf_verdict.sv */
// End-of-frame decision, match counters and the result register.
// Depends on tuf_pkg for the header struct, protocol numbers and sizes.
module tuf_verdict #(
  parameter int unsigned COUNT_WIDTH = tuf_pkg::CountWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          done_i,
  input  logic          dir_i,
  input  tuf_pkg::hdr_t hdr_i,
  input  tuf_pkg::cfg_t cfg_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          verdict_drop_o,
  output logic          port_matched_o,
  output logic [31:0]   source_address_o,
  output logic [31:0]   dest_address_o,
  output logic [15:0]   source_port_o,
  output logic [15:0]   dest_port_o,
  output logic [15:0]   ip_total_length_o,
  output logic [7:0]    ip_protocol_o,
  output logic          direction_out_o,
  output logic [31:0]   ingress_match_total_o,
  output logic [31:0]   egress_match_total_o,
  output logic [31:0]   drop_total_o
);
  import tuf_pkg::*;

  localparam int unsigned ExtW = (COUNT_WIDTH > OutCntW) ? COUNT_WIDTH : OutCntW;

  logic [COUNT_WIDTH-1:0] ing_q, ing_d, egr_q, egr_d, drp_q, drp_d;
  logic [ExtW-1:0]        ing_ext, egr_ext, drp_ext;
  logic [LenW-1:0]        need;
  logic                   is_tcp, is_udp, hit, drop;
  logic                   valid_q, valid_d;

  assign is_tcp = hdr_i.proto == ProtoTcp;
  assign is_udp = hdr_i.proto == ProtoUdp;
  assign need   = EthHdrBytes + {2'b00, hdr_i.ihl, 2'b00} +
                  (is_tcp ? TcpHdrBytes : UdpHdrBytes);

  assign hit = (hdr_i.len >= EthHdrBytes + IpMinBytes) &&
               (hdr_i.eth_type == EthTypeIpv4) &&
               (is_tcp || is_udp) &&
               (hdr_i.ihl >= IhlMin) &&
               (hdr_i.len >= need) &&
               (cfg_i.watched_port != 16'd0) &&
               (hdr_i.src_port == cfg_i.watched_port ||
                hdr_i.dst_port == cfg_i.watched_port);
  assign drop = hit && cfg_i.drop_enable;

  always_comb begin
    ing_d = ing_q;
    egr_d = egr_q;
    drp_d = drp_q;
    if (hit) begin
      if (dir_i) begin
        ing_d = ing_q + COUNT_WIDTH'(1);
      end else begin
        egr_d = egr_q + COUNT_WIDTH'(1);
      end
      if (drop) begin
        drp_d = drp_q + COUNT_WIDTH'(1);
      end
    end
  end

  assign ing_ext = ExtW'(ing_d);
  assign egr_ext = ExtW'(egr_d);
  assign drp_ext = ExtW'(drp_d);

  // The upstream stage only finishes a frame when this register is free or
  // being emptied, so a new result never overwrites an untaken one.
  assign valid_d = done_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ing_q   <= '0;
      egr_q   <= '0;
      drp_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (done_i) begin
        ing_q <= ing_d;
        egr_q <= egr_d;
        drp_q <= drp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i) begin
      verdict_drop_o        <= drop ? VerdictDrop : VerdictPass;
      port_matched_o        <= hit;
      source_address_o      <= hit ? hdr_i.src_addr : 32'd0;
      dest_address_o        <= hit ? hdr_i.dst_addr : 32'd0;
      source_port_o         <= hit ? hdr_i.src_port : 16'd0;
      dest_port_o           <= hit ? hdr_i.dst_port : 16'd0;
      ip_total_length_o     <= hit ? hdr_i.tot_len : 16'd0;
      ip_protocol_o         <= hit ? hdr_i.proto : 8'd0;
      direction_out_o       <= dir_i;
      ingress_match_total_o <= ing_ext[OutCntW-1:0];
      egress_match_total_o  <= egr_ext[OutCntW-1:0];
      drop_total_o          <= drp_ext[OutCntW-1:0];
    end
  end

  assign out_valid_o = valid_q;

endmodule

/* rtl/core/tcp_udp_port_match_filter.sv */
// IPv4 TCP/UDP port-match filter. Takes one frame byte per cycle, back to
// back, as long as the result register is free; the verdict of the byte
// marked last goes through the input register, then header capture and
// decision into the result register.
// Bytes that are not last never wait on the output side; only a last byte
// waits while an earlier verdict is still not taken. Registers: watched port
// at address 0, drop enable at address 4; write them only while idle.
module tcp_udp_port_match_filter #(
  parameter int unsigned COUNT_WIDTH = tuf_pkg::CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  input  logic        from_guest_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        verdict_drop_o,
  output logic        port_matched_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [15:0] ip_total_length_o,
  output logic [7:0]  ip_protocol_o,
  output logic        direction_out_o,
  output logic [31:0] ingress_match_total_o,
  output logic [31:0] egress_match_total_o,
  output logic [31:0] drop_total_o
);
  import tuf_pkg::*;

  cfg_t       cfg;
  hdr_t       hdr;
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       dir_q;
  logic       step;

  // A held byte moves on unless it ends a frame and the result slot is busy.
  assign step       = in_valid_q & (~last_q | ~out_valid_o | out_ready_i);
  assign in_ready_o = ~in_valid_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= frame_byte_i;
      last_q <= frame_last_i;
      dir_q  <= from_guest_i;
    end
  end

  tuf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tuf_hdr_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .last_i (last_q),
    .hdr_o  (hdr)
  );

  tuf_verdict #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_verdict (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .done_i                (step & last_q),
    .dir_i                 (dir_q),
    .hdr_i                 (hdr),
    .cfg_i                 (cfg),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .verdict_drop_o        (verdict_drop_o),
    .port_matched_o        (port_matched_o),
    .source_address_o      (source_address_o),
    .dest_address_o        (dest_address_o),
    .source_port_o         (source_port_o),
    .dest_port_o           (dest_port_o),
    .ip_total_length_o     (ip_total_length_o),
    .ip_protocol_o         (ip_protocol_o),
    .direction_out_o       (direction_out_o),
    .ingress_match_total_o (ingress_match_total_o),
    .egress_match_total_o  (egress_match_total_o),
    .drop_total_o          (drop_total_o)
  );

endmodule

/* rtl/core/tuf_checker.sv */
// Port-level checks of the port-match filter, bound to its top level.
// Depends on tcp_udp_port_match_filter_assert.svh and tuf_pkg.
`include "tcp_udp_port_match_filter_assert.svh"

module tuf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        verdict_drop_i,
  input logic        port_matched_i,
  input logic [31:0] source_address_i,
  input logic [31:0] dest_address_i,
  input logic [15:0] source_port_i,
  input logic [7:0]  ip_protocol_i,
  input logic [31:0] drop_total_i
);
  import tuf_pkg::*;

  // A waiting result keeps its verdict and counters until taken.
  `TUF_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(verdict_drop_i) && $stable(drop_total_i), "result changed while stalled")

  // Only a matched frame can be dropped.
  `TUF_ASSERT_IMP(a_drop_needs_match, clk_i, rst_ni, out_valid_i && verdict_drop_i, port_matched_i, "drop without a port match")

  // Flow fields are zero when the frame did not match.
  `TUF_ASSERT_IMP(a_flow_zero, clk_i, rst_ni, out_valid_i && !port_matched_i, source_address_i == 32'd0 && dest_address_i == 32'd0 && source_port_i == 16'd0 && ip_protocol_i == 8'd0, "flow fields set on unmatched frame")

  // A match is only ever TCP or UDP.
  `TUF_ASSERT_IMP(a_match_proto, clk_i, rst_ni, out_valid_i && port_matched_i, ip_protocol_i == ProtoTcp || ip_protocol_i == ProtoUdp, "match on a protocol other than TCP or UDP")

endmodule

bind tcp_udp_port_match_filter tuf_checker u_tuf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .verdict_drop_i   (verdict_drop_o),
  .port_matched_i   (port_matched_o),
  .source_address_i (source_address_o),
  .dest_address_i   (dest_address_o),
  .source_port_i    (source_port_o),
  .ip_protocol_i    (ip_protocol_o),
  .drop_total_i     (drop_total_o)
);

/* tb/tb_tcp_udp_port_match_filter.sv */
// Self-checking testbench of the TCP/UDP port-match filter: drives frames byte by byte,
// predicts every verdict and compares it field by field with what the block returns.
// Depends on tuf_pkg and tcp_udp_port_match_filter only.
module tb_tcp_udp_port_match_filter;
  import tuf_pkg::*;

  localparam int unsigned LongHold  = 400;
  localparam int unsigned MaxReport = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       guest;
  } frame_byte_t;

  typedef struct packed {
    logic        drop;
    logic        matched;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic        dir;
    logic [31:0] ingress;
    logic [31:0] egress;
    logic [31:0] drops;
  } verdict_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = '0;
  logic        frame_last = 1'b0;
  logic        from_guest = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        verdict_drop, port_matched, direction_out;
  logic [31:0] source_address, dest_address;
  logic [15:0] source_port, dest_port, ip_total_length;
  logic [7:0]  ip_protocol;
  logic [31:0] ingress_match_total, egress_match_total, drop_total;
  verdict_t    seen;

  // Stimulus and expectations.
  frame_byte_t byte_queue[$];
  frame_byte_t next_byte;
  verdict_t    verdict_q[$];
  int unsigned fail_count   = 0;
  int unsigned bytes_pushed = 0;
  int unsigned frames_built = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_ack     = 0;
  int unsigned hold_left    = 0;

  // Model copy of the registers and of the per-frame capture state.
  logic [15:0]              watch_port = '0;
  logic                     drop_on    = 1'b0;
  int                       pos        = 0;
  logic [15:0]              eth_type   = '0;
  logic [3:0]               ihl        = '0;
  logic [7:0]               proto      = '0;
  logic [15:0]              tot_len    = '0;
  logic [31:0]              saddr      = '0;
  logic [31:0]              daddr      = '0;
  logic [15:0]              sport      = '0;
  logic [15:0]              dport      = '0;
  logic [CountWidthDef-1:0] cnt_ingress = '0;
  logic [CountWidthDef-1:0] cnt_egress  = '0;
  logic [CountWidthDef-1:0] cnt_drop    = '0;

  tcp_udp_port_match_filter i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .frame_byte_i          (frame_byte),
    .frame_last_i          (frame_last),
    .from_guest_i          (from_guest),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .verdict_drop_o        (verdict_drop),
    .port_matched_o        (port_matched),
    .source_address_o      (source_address),
    .dest_address_o        (dest_address),
    .source_port_o         (source_port),
    .dest_port_o           (dest_port),
    .ip_total_length_o     (ip_total_length),
    .ip_protocol_o         (ip_protocol),
    .direction_out_o       (direction_out),
    .ingress_match_total_o (ingress_match_total),
    .egress_match_total_o  (egress_match_total),
    .drop_total_o          (drop_total)
  );

  assign seen = {verdict_drop, port_matched, source_address, dest_address, source_port,
                 dest_port, ip_total_length, ip_protocol, direction_out,
                 ingress_match_total, egress_match_total, drop_total};

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Captures header fields from one accepted byte and, on the last byte, works out the
  // verdict of the frame.
  task automatic track_byte(input logic [7:0] b, input logic last, input logic guest);
    int       p;
    int       l4;
    int       need;
    logic     hit;
    verdict_t v;
    p  = pos;
    l4 = int'(EthHdrBytes) + 4 * int'(ihl);
    if (p < int'(PosMax)) begin
      if (p == int'(PosEthType) || p == int'(PosEthType) + 1) eth_type = {eth_type[7:0], b};
      if (p == int'(PosIhl)) ihl = b[3:0];
      if (p == int'(PosTotLen) || p == int'(PosTotLen) + 1) tot_len = {tot_len[7:0], b};
      if (p == int'(PosProto)) proto = b;
      if (p >= int'(PosSrcAddr) && p < int'(PosSrcAddr) + 4) saddr = {saddr[23:0], b};
      if (p >= int'(PosDstAddr) && p < int'(PosDstAddr) + 4) daddr = {daddr[23:0], b};
      // The port offset is only known once the header length byte has gone by.
      if (p > int'(PosIhl) && (p == l4 || p == l4 + 1)) sport = {sport[7:0], b};
      if (p > int'(PosIhl) && (p == l4 + 2 || p == l4 + 3)) dport = {dport[7:0], b};
      pos = p + 1;
    end
    if (!last) return;
    need = int'(EthHdrBytes) + 4 * int'(ihl) +
           ((proto == ProtoTcp) ? int'(TcpHdrBytes) : int'(UdpHdrBytes));
    hit = (p + 1 >= int'(EthHdrBytes) + int'(IpMinBytes)) && (eth_type == EthTypeIpv4) &&
          (proto == ProtoTcp || proto == ProtoUdp) && (ihl >= IhlMin) && (p + 1 >= need) &&
          (watch_port != '0) && (sport == watch_port || dport == watch_port);
    if (hit) begin
      if (guest) cnt_ingress = cnt_ingress + 1'b1;
      else cnt_egress = cnt_egress + 1'b1;
      if (drop_on) cnt_drop = cnt_drop + 1'b1;
    end
    v.drop     = (hit && drop_on) ? VerdictDrop : VerdictPass;
    v.matched  = hit;
    v.src_addr = hit ? saddr : '0;
    v.dst_addr = hit ? daddr : '0;
    v.src_port = hit ? sport : '0;
    v.dst_port = hit ? dport : '0;
    v.tot_len  = hit ? tot_len : '0;
    v.proto    = hit ? proto : '0;
    v.dir      = guest;
    v.ingress  = cnt_ingress[OutCntW-1:0];
    v.egress   = cnt_egress[OutCntW-1:0];
    v.drops    = cnt_drop[OutCntW-1:0];
    verdict_q.push_back(v);
    pos      = 0;
    eth_type = '0;
    ihl      = '0;
    proto    = '0;
    tot_len  = '0;
    saddr    = '0;
    daddr    = '0;
    sport    = '0;
    dport    = '0;
  endtask

  function automatic string show(verdict_t v);
    return $sformatf({"drop=%0b hit=%0b saddr=%h daddr=%h sport=%0d dport=%0d len=%0d ",
                      "proto=%0d dir=%0b in=%0d eg=%0d drops=%0d"},
                     v.drop, v.matched, v.src_addr, v.dst_addr, v.src_port, v.dst_port,
                     v.tot_len, v.proto, v.dir, v.ingress, v.egress, v.drops);
  endfunction

  // Driver: offers queued bytes, predicting each one as it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_byte(frame_byte, frame_last, from_guest);
      if (!in_valid || in_ready) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_byte = byte_queue.pop_front();
          in_valid   <= 1'b1;
          frame_byte <= next_byte.data;
          frame_last <= next_byte.last;
          from_guest <= next_byte.guest;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= LongHold;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks every accepted verdict against the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReport) $display("Unexpected verdict: %s", show(seen));
        end else if (seen !== verdict_q[0]) begin
          fail_count++;
          if (fail_count <= MaxReport) begin
            $display("Verdict mismatch\n  expected %s\n  actual   %s",
                     show(verdict_q[0]), show(seen));
          end
          void'(verdict_q.pop_front());
        end else begin
          void'(verdict_q.pop_front());
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CfgWatchedPort: watch_port = val[15:0];
      CfgDropEnable:  drop_on = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Mode 0: sender idles rarely and receiver often, mode 1 the reverse, mode 2 no idling.
  task automatic set_phase(input logic [15:0] port, input logic drop, input int mode);
    write_reg(CfgWatchedPort, {16'h0, port});
    write_reg(CfgDropEnable, {31'h0, drop});
    snd_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 72 : 0;
    rcv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 17 : 0;
  endtask

  // Lets the block finish all queued work, then lets its pipeline settle.
  task automatic drain(input int settle);
    while (byte_queue.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Builds one frame of random bytes with the given header fields laid over it.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] vihl,
                             input logic [7:0] prot, input logic [15:0] tlen,
                             input logic [31:0] sa, input logic [31:0] da,
                             input logic [15:0] sp, input logic [15:0] dp,
                             input int nbytes, input logic guest);
    logic [7:0]  f[$];
    logic [31:0] ports;
    int          l4;
    int          i;
    frame_byte_t fb;
    for (i = 0; i < nbytes; i++) f.push_back(8'($urandom));
    l4    = int'(EthHdrBytes) + 4 * int'(vihl[3:0]);
    ports = {sp, dp};
    for (i = 0; i < 4; i++) if (l4 + i < nbytes) f[l4 + i] = ports[31 - 8 * i -: 8];
    for (i = 0; i < nbytes && i < int'(PosDstAddr) + 4; i++) begin
      if (i == int'(PosEthType)) f[i] = etype[15:8];
      if (i == int'(PosEthType) + 1) f[i] = etype[7:0];
      if (i == int'(PosIhl)) f[i] = vihl;
      if (i == int'(PosTotLen)) f[i] = tlen[15:8];
      if (i == int'(PosTotLen) + 1) f[i] = tlen[7:0];
      if (i == int'(PosProto)) f[i] = prot;
      if (i >= int'(PosSrcAddr) && i < int'(PosSrcAddr) + 4)
        f[i] = sa[31 - 8 * (i - int'(PosSrcAddr)) -: 8];
      if (i >= int'(PosDstAddr) && i < int'(PosDstAddr) + 4)
        f[i] = da[31 - 8 * (i - int'(PosDstAddr)) -: 8];
    end
    for (i = 0; i < nbytes; i++) begin
      fb.data  = f[i];
      fb.last  = (i == nbytes - 1);
      fb.guest = fb.last ? guest : 1'($urandom);
      byte_queue.push_back(fb);
    end
    bytes_pushed += nbytes;
    frames_built++;
  endtask

  // Mostly well-formed frames that may hit the watched port, some with one defect,
  // the rest random noise.
  task automatic rand_frame();
    int          kind;
    int          hlen;
    int          need;
    int          nbytes;
    logic [7:0]  prot;
    logic [7:0]  vihl;
    logic [15:0] etype;
    logic [15:0] sp;
    logic [15:0] dp;
    kind  = $urandom_range(99);
    prot  = $urandom_range(1) ? ProtoTcp : ProtoUdp;
    hlen  = ($urandom_range(4) == 0) ? $urandom_range(15, 5) : 5;
    vihl  = {(($urandom_range(7) == 0) ? 4'($urandom) : 4'd4), 4'(hlen)};
    etype = EthTypeIpv4;
    sp    = 16'($urandom);
    dp    = 16'($urandom);
    case ($urandom_range(3))
      0: sp = watch_port;
      1: dp = watch_port;
      2: begin
        sp = watch_port;
        dp = watch_port;
      end
      default: ;
    endcase
    need = int'(EthHdrBytes) + 4 * hlen +
           ((prot == ProtoTcp) ? int'(TcpHdrBytes) : int'(UdpHdrBytes));
    nbytes = ($urandom_range(19) == 0) ? $urandom_range(140, need) : need + $urandom_range(6);
    if (kind >= 65 && kind < 80) begin
      case ($urandom_range(3))
        0: nbytes = $urandom_range(need - 1, 1);
        1: etype = 16'($urandom);
        2: prot = 8'($urandom);
        default: vihl[3:0] = 4'($urandom_range(4));
      endcase
    end else if (kind >= 80) begin
      nbytes = $urandom_range(60, 1);
      etype  = 16'($urandom);
      vihl   = 8'($urandom);
      prot   = 8'($urandom);
    end
    build_frame(etype, vihl, prot, 16'($urandom), $urandom, $urandom, sp, dp, nbytes,
                1'($urandom));
  endtask

  initial begin
    int unsigned b0;
    int unsigned f0;
    logic [15:0] port;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Watched port zero disables matching, even for frames whose ports are zero.
    set_phase(16'h0, 1'b0, 0);
    build_frame(EthTypeIpv4, 8'h45, ProtoTcp, 16'd40, 32'h0a000001, 32'h0a000002,
                16'h0, 16'h0, 54, 1'b1);
    build_frame(EthTypeIpv4, 8'h45, ProtoUdp, 16'd28, 32'h0, 32'h0, 16'h0, 16'h0, 1, 1'b0);
    drain(4);

    set_phase(16'hFFFF, 1'b1, 0);
    build_frame(EthTypeIpv4, 8'h45, ProtoTcp, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'd80, 54, 1'b1);
    build_frame(EthTypeIpv4, 8'h45, ProtoUdp, 16'hFFFF, 32'hFFFFFFFF, 32'h0,
                16'd53, 16'hFFFF, 42, 1'b0);
    // One byte short of the full L4 header.
    build_frame(EthTypeIpv4, 8'h45, ProtoUdp, 16'd28, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 41, 1'b1);
    build_frame(EthTypeIpv4, 8'h45, ProtoTcp, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 53, 1'b0);
    build_frame(EthTypeIpv4, 8'h4F, ProtoTcp, 16'd80, $urandom, $urandom,
                16'd22, 16'hFFFF, 94, 1'b1);
    build_frame(EthTypeIpv4, 8'h44, ProtoTcp, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 54, 1'b1);
    build_frame(EthTypeIpv4, 8'h40, ProtoTcp, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 54, 1'b0);
    build_frame(16'h86DD, 8'h45, ProtoTcp, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 54, 1'b1);
    build_frame(16'h0008, 8'h45, ProtoUdp, 16'd28, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 42, 1'b1);
    build_frame(EthTypeIpv4, 8'h45, 8'd1, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 54, 1'b0);
    build_frame(EthTypeIpv4, 8'h45, 8'hFF, 16'd40, $urandom, $urandom,
                16'hFFFF, 16'hFFFF, 54, 1'b1);
    // The version nibble is ignored.
    build_frame(EthTypeIpv4, 8'h05, ProtoUdp, 16'd28, $urandom, $urandom,
                16'hFFFF, 16'd0, 42, 1'b1);
    build_frame(EthTypeIpv4, 8'hF5, ProtoTcp, 16'd40, $urandom, $urandom,
                16'd0, 16'hFFFF, 54, 1'b0);
    // Bytes past the capture window must not disturb the verdict.
    build_frame(EthTypeIpv4, 8'h45, ProtoTcp, 16'd136, $urandom, $urandom,
                16'hFFFF, 16'd443, 150, 1'b0);
    drain(4);

    // Matches that pass because dropping is off.
    set_phase(16'd1, 1'b0, 0);
    build_frame(EthTypeIpv4, 8'h45, ProtoUdp, 16'd0, 32'h0, 32'hFFFFFFFF,
                16'd1, 16'd2, 42, 1'b1);
    build_frame(EthTypeIpv4, 8'h45, ProtoTcp, 16'd40, $urandom, $urandom,
                16'd7, 16'd1, 54, 1'b0);
    drain(4);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: port = 16'($urandom_range(1023, 1));
        1: port = 16'h0;
        3: port = 16'hFFFF;
        4: port = 16'd1;
        default: port = 16'($urandom_range(65535, 1));
      endcase
      set_phase(port, ~ph[0], ph / 2);
      // With no idling, park the receiver for a while so the block backs up.
      if (ph == 4) hold_req++;
      b0 = bytes_pushed;
      f0 = frames_built;
      while (bytes_pushed - b0 < 40 || frames_built - f0 < 2) rand_frame();
      drain(4);
    end

    drain(8);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
